[design/escfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escfr_pkg
// Codes, phases and constants of the escaped serial frame receiver.
// ----------------------------------------------------------------------------
package escfr_pkg;

    // Framing bytes and checksum seed
    localparam logic [7:0] ESC_CODE   = 8'h07;
    localparam logic [7:0] START_CODE = 8'hF0;
    localparam logic [7:0] END_CODE   = 8'h0F;
    localparam logic [7:0] SUM_INIT   = 8'd173;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_START  = 3'd1;
    localparam logic [2:0] ST_CMD_MISS   = 3'd2;
    localparam logic [2:0] ST_TOO_LONG   = 3'd3;
    localparam logic [2:0] ST_BAD_ESCAPE = 3'd4;
    localparam logic [2:0] ST_CHECKSUM   = 3'd5;
    localparam logic [2:0] ST_BAD_END    = 3'd6;

    // Configuration register indexes
    localparam logic CFG_REQ_CMD = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    // Reset value of the length limit
    localparam logic [7:0] MAX_LEN_RESET = 8'd32;

    // Result packing widths
    localparam int TDATA_W = 32;
    localparam int TUSER_W = 2;

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START   = 3'd1,
        PH_CMD     = 3'd2,
        PH_LEN     = 3'd3,
        PH_DATA    = 3'd4,
        PH_SUM     = 3'd5,
        PH_END_ESC = 3'd6,
        PH_END     = 3'd7
    } t_phase;

endpackage

[design/escaped_frame_receiver_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_receiver_unit
// Parses escaped serial reply frames one byte at a time and reports each
// data byte, a frame success with length and acknowledge, or an error code.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid / tready    tdata[7:0] received byte
// m_axis    out  tvalid / tready    tdata: byte, index, status, length, ack
//                                   tuser: result kind
// cfg       in   wr_en              index 0 request command, 1 max length
//
// One byte is accepted every cycle unless the output stalls; each byte passes
// through the input register, then its result is held in the result register.
// The parser state advances in a single pass per byte from the input register.
// A stalled output holds the result register and, once the input register is
// also full, drops s_axis tready. Synchronous active-low reset returns the
// parser to waiting for a start escape and loads the register defaults.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_unit
    import escfr_pkg::*;
#(
    parameter int COMMAND_BYTES = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // received byte stream; tdata: rx_byte[7:0]
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,
    // result stream; tdata: data_byte[7:0], data_index[15:8], status[18:16],
    // frame_length[26:19], ack_req[27], zero[31:28]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [TDATA_W-1:0]   o_m_axis_tdata,
    // tuser: kind[1:0]
    output logic [TUSER_W-1:0]   o_m_axis_tuser,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_wdata
);

    localparam int CMD_W = 8 * COMMAND_BYTES;
    localparam int EXP_W = (CMD_W > 17) ? CMD_W : 17;

    // Configuration
    logic [15:0]        r_req_cmd;
    logic [7:0]         r_max_len;

    // Input register
    logic               r_in_valid;
    logic [7:0]         r_in_byte;

    // Parser state
    t_phase             r_phase,    n_phase;
    logic [7:0]         r_sum,      n_sum;
    logic [CMD_W-1:0]   r_cmd,      n_cmd;
    logic [7:0]         r_len,      n_len;
    logic [7:0]         r_cnt,      n_cnt;
    logic               r_esc,      n_esc;

    // Result register
    logic               r_out_valid;
    logic [TDATA_W-1:0] r_out_data;
    logic [TUSER_W-1:0] r_out_kind;

    // Per-byte decisions
    logic               w_proc;
    logic               w_fail;
    logic [2:0]         w_fail_code;
    logic               w_emit_data;
    logic               w_emit_done;
    logic               w_has_res;
    logic [CMD_W-1:0]   w_got;
    logic [EXP_W-1:0]   w_expect_full;
    logic [CMD_W-1:0]   w_expect;
    logic [1:0]         w_kind;
    logic [7:0]         w_dbyte;
    logic [7:0]         w_didx;
    logic [2:0]         w_status;
    logic [7:0]         w_flen;
    logic               w_ack;

    // Handshake: process when the result register is free or being emptied
    assign w_proc          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_proc;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;

    // Command assembly and expected reply command
    assign w_got         = CMD_W'({r_cmd, r_in_byte});
    assign w_expect_full = EXP_W'(r_req_cmd) + EXP_W'(1);
    assign w_expect      = w_expect_full[CMD_W-1:0];

    // Next parser state
    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_esc       = r_esc;
        w_fail      = 1'b0;
        w_fail_code = ST_OK;
        w_emit_data = 1'b0;
        w_emit_done = 1'b0;
        if (w_proc) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_in_byte != ESC_CODE) begin
                        w_fail      = 1'b1;
                        w_fail_code = ST_BAD_START;
                    end else begin
                        n_phase = PH_START;
                    end
                end
                PH_START: begin
                    if (r_in_byte != START_CODE) begin
                        w_fail      = 1'b1;
                        w_fail_code = ST_BAD_START;
                    end else begin
                        n_phase = PH_CMD;
                        n_sum   = SUM_INIT;
                        n_cmd   = '0;
                        n_cnt   = 8'd0;
                    end
                end
                PH_CMD: begin
                    n_sum = r_sum + r_in_byte;
                    n_cnt = r_cnt + 8'd1;
                    if (n_cnt < 8'(COMMAND_BYTES)) begin
                        n_cmd = w_got;
                    end else if (w_got != w_expect) begin
                        w_fail      = 1'b1;
                        w_fail_code = ST_CMD_MISS;
                    end else begin
                        n_phase = PH_LEN;
                        n_cnt   = 8'd0;
                    end
                end
                PH_LEN: begin
                    n_sum = r_sum + r_in_byte;
                    if (r_in_byte > r_max_len) begin
                        w_fail      = 1'b1;
                        w_fail_code = ST_TOO_LONG;
                    end else begin
                        n_len   = r_in_byte;
                        n_cnt   = 8'd0;
                        n_esc   = 1'b0;
                        n_phase = (r_in_byte == 8'd0) ? PH_SUM : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (r_esc && (r_in_byte != ESC_CODE)) begin
                        w_fail      = 1'b1;
                        w_fail_code = ST_BAD_ESCAPE;
                    end else if (!r_esc && (r_in_byte == ESC_CODE)) begin
                        n_esc = 1'b1;
                    end else begin
                        w_emit_data = 1'b1;
                        n_esc       = 1'b0;
                        n_sum       = r_sum + r_in_byte;
                        n_cnt       = r_cnt + 8'd1;
                        if (n_cnt >= r_len) begin
                            n_phase = PH_SUM;
                        end
                    end
                end
                PH_SUM: begin
                    if (r_in_byte != r_sum) begin
                        w_fail      = 1'b1;
                        w_fail_code = ST_CHECKSUM;
                    end else begin
                        n_phase = PH_END_ESC;
                    end
                end
                PH_END_ESC: begin
                    if (r_in_byte != ESC_CODE) begin
                        w_fail      = 1'b1;
                        w_fail_code = ST_BAD_END;
                    end else begin
                        n_phase = PH_END;
                    end
                end
                PH_END: begin
                    if (r_in_byte != END_CODE) begin
                        w_fail      = 1'b1;
                        w_fail_code = ST_BAD_END;
                    end else begin
                        w_emit_done = 1'b1;
                    end
                end
            endcase
            // Any end of frame, good or bad, returns to waiting for start
            if (w_fail || w_emit_done) begin
                n_phase = PH_IDLE;
                n_sum   = SUM_INIT;
                n_cmd   = '0;
                n_len   = 8'd0;
                n_cnt   = 8'd0;
                n_esc   = 1'b0;
            end
        end
    end

    // Result fields
    always_comb begin
        w_has_res = w_fail || w_emit_data || w_emit_done;
        w_kind    = KIND_DATA;
        w_dbyte   = 8'd0;
        w_didx    = 8'd0;
        w_status  = ST_OK;
        w_flen    = 8'd0;
        w_ack     = 1'b0;
        priority if (w_fail) begin
            w_kind   = KIND_ERROR;
            w_status = w_fail_code;
        end else if (w_emit_done) begin
            w_kind = KIND_OK;
            w_flen = r_len;
            w_ack  = 1'b1;
        end else if (w_emit_data) begin
            w_dbyte = r_in_byte;
            w_didx  = r_cnt;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_cmd <= 16'd0;
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_REQ_CMD: r_req_cmd <= i_cfg_wdata;
                CFG_MAX_LEN: r_max_len <= i_cfg_wdata[7:0];
            endcase
        end
    end

    // Input register: load on a transaction, drain when processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sum   <= SUM_INIT;
            r_cmd   <= '0;
            r_len   <= 8'd0;
            r_cnt   <= 8'd0;
            r_esc   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_esc   <= n_esc;
        end
    end

    // Result register: load a new result, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && w_has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_has_res) begin
            r_out_data <= {4'd0, w_ack, w_flen, w_status, w_didx, w_dbyte};
            r_out_kind <= w_kind;
        end
    end

`ifndef SYNTHESIS
    // A frame result always sends the parser back to waiting for start
    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fail || w_emit_done) |=> (r_phase == PH_IDLE))
        else $error("parser not idle after frame result");

    // Never overwrite a result that is stalled downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_proc && r_out_valid && !i_m_axis_tready))
        else $error("processing while result register is stalled");

    // A pending escape exists only inside the data field
    a_esc_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> (r_phase == PH_DATA))
        else $error("escape pending outside data phase");

    // Data index stays below the announced length
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_cnt < r_len))
        else $error("data count reached frame length in data phase");
`endif

endmodule

[tb/sv/escfr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escfr_checker
// Watches the byte and result streams of the escaped frame receiver. It keeps
// its own copy of the parser state and registers, and works out the result
// that each accepted byte should cause. It then checks every result
// transaction, field by field, against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module escfr_checker
    import escfr_pkg::*;
#(
    parameter int COMMAND_BYTES = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // received byte stream; tdata: rx_byte[7:0]
    input  logic                 i_s_axis_tvalid,
    input  logic                 i_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,
    // result stream; tdata: data_byte[7:0], data_index[15:8], status[18:16],
    // frame_length[26:19], ack_req[27], zero[31:28]
    input  logic                 i_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    input  logic [TDATA_W-1:0]   i_m_axis_tdata,
    // tuser: kind[1:0]
    input  logic [TUSER_W-1:0]   i_m_axis_tuser,
    // configuration write port
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic [2:0] status;
        logic [7:0] frame_length;
        logic       ack_req;
    } t_frame_result;

    // Register copies
    logic [15:0]    req_cmd;
    logic [7:0]     max_len;

    // Parser copy
    t_phase         rx_phase;
    logic [7:0]     rx_sum;
    logic [23:0]    rx_cmd_high;
    logic [7:0]     rx_len;
    logic [7:0]     rx_count;
    logic           rx_esc;

    t_frame_result  expected_q[$];
    t_frame_result  seen_r;
    t_frame_result  want_r;
    int             mismatches = 0;
    int             results_checked = 0;

    // Return to waiting for a start escape
    function automatic void go_idle();
        rx_phase    = PH_IDLE;
        rx_sum      = SUM_INIT;
        rx_cmd_high = '0;
        rx_len      = '0;
        rx_count    = '0;
        rx_esc      = 1'b0;
    endfunction

    // Abort the frame and expect an error report
    function automatic void report_fault(logic [2:0] code);
        t_frame_result r;
        r        = '0;
        r.kind   = KIND_ERROR;
        r.status = code;
        go_idle();
        expected_q.push_back(r);
    endfunction

    // Advance the parser copy by one received byte
    function automatic void parse_byte(logic [7:0] b);
        logic [63:0]   got;
        logic [63:0]   mask;
        t_frame_result r;
        mask = (64'd1 << (8 * COMMAND_BYTES)) - 64'd1;
        r    = '0;
        case (rx_phase)
            PH_START: begin
                if (b != START_CODE) begin
                    report_fault(ST_BAD_START);
                end else begin
                    rx_phase    = PH_CMD;
                    rx_sum      = SUM_INIT;
                    rx_cmd_high = '0;
                    rx_count    = '0;
                end
            end
            PH_CMD: begin
                got      = {32'd0, rx_cmd_high, b} & mask;
                rx_sum   = rx_sum + b;
                rx_count = rx_count + 8'd1;
                if (rx_count < COMMAND_BYTES) begin
                    rx_cmd_high = got[23:0];
                end else if (got != ((64'(req_cmd) + 64'd1) & mask)) begin
                    report_fault(ST_CMD_MISS);
                end else begin
                    rx_phase = PH_LEN;
                    rx_count = '0;
                end
            end
            PH_LEN: begin
                rx_sum = rx_sum + b;
                if (b > max_len) begin
                    report_fault(ST_TOO_LONG);
                end else begin
                    rx_len   = b;
                    rx_count = '0;
                    rx_esc   = 1'b0;
                    rx_phase = (b == 8'd0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA: begin
                if (rx_esc && b != ESC_CODE) begin
                    report_fault(ST_BAD_ESCAPE);
                end else if (!rx_esc && b == ESC_CODE) begin
                    // hold the first half of a doubled escape
                    rx_esc = 1'b1;
                end else begin
                    rx_esc       = 1'b0;
                    r.kind       = KIND_DATA;
                    r.data_byte  = b;
                    r.data_index = rx_count;
                    rx_sum       = rx_sum + b;
                    rx_count     = rx_count + 8'd1;
                    if (rx_count >= rx_len) rx_phase = PH_SUM;
                    expected_q.push_back(r);
                end
            end
            PH_SUM: begin
                if (b != rx_sum) report_fault(ST_CHECKSUM);
                else rx_phase = PH_END_ESC;
            end
            PH_END_ESC: begin
                if (b != ESC_CODE) report_fault(ST_BAD_END);
                else rx_phase = PH_END;
            end
            PH_END: begin
                if (b != END_CODE) begin
                    report_fault(ST_BAD_END);
                end else begin
                    r.kind         = KIND_OK;
                    r.frame_length = rx_len;
                    r.ack_req      = 1'b1;
                    go_idle();
                    expected_q.push_back(r);
                end
            end
            default: begin
                if (b != ESC_CODE) report_fault(ST_BAD_START);
                else rx_phase = PH_START;
            end
        endcase
    endfunction

    function automatic int field_mismatch(string name, int unsigned want, int unsigned got);
        if (want == got) return 0;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    // Track registers, predict on byte transactions, compare result transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_cmd = '0;
            max_len = MAX_LEN_RESET;
            go_idle();
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_REQ_CMD: req_cmd = i_cfg_wdata;
                    CFG_MAX_LEN: max_len = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) parse_byte(i_s_axis_tdata);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                seen_r.kind         = i_m_axis_tuser[1:0];
                seen_r.data_byte    = i_m_axis_tdata[7:0];
                seen_r.data_index   = i_m_axis_tdata[15:8];
                seen_r.status       = i_m_axis_tdata[18:16];
                seen_r.frame_length = i_m_axis_tdata[26:19];
                seen_r.ack_req      = i_m_axis_tdata[27];
                if (expected_q.size() == 0) begin
                    $error("unexpected result: kind %0d, tdata 0x%h", seen_r.kind,
                           i_m_axis_tdata);
                    mismatches++;
                end else begin
                    want_r = expected_q.pop_front();
                    results_checked++;
                    mismatches += field_mismatch("kind", want_r.kind, seen_r.kind);
                    mismatches += field_mismatch("data_byte", want_r.data_byte,
                                                 seen_r.data_byte);
                    mismatches += field_mismatch("data_index", want_r.data_index,
                                                 seen_r.data_index);
                    mismatches += field_mismatch("status", want_r.status, seen_r.status);
                    mismatches += field_mismatch("frame_length", want_r.frame_length,
                                                 seen_r.frame_length);
                    mismatches += field_mismatch("ack_req", want_r.ack_req,
                                                 seen_r.ack_req);
                end
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= mismatches;
        o_checked    <= results_checked;
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives reply frames into the escaped frame receiver: a short directed set,
// then well-formed frames with random content mixed with broken frames and
// line noise, under several register settings and handshake idling modes.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench
    import escfr_pkg::*;
;

    localparam int CMD_BYTES     = 2;
    localparam int N_PHASES      = 8;
    localparam int PHASE_BYTES   = 40;
    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 2000;

    typedef enum int {
        FLT_NONE,
        FLT_NOISE,
        FLT_START_ESC,
        FLT_START,
        FLT_CMD,
        FLT_TOO_LONG,
        FLT_ESCAPE,
        FLT_SUM,
        FLT_END_ESC,
        FLT_END
    } t_fault;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               rx_valid = 1'b0;
    logic               rx_ready;
    logic [7:0]         rx_data = 8'd0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic [TDATA_W-1:0] res_data;
    logic [TUSER_W-1:0] res_kind;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = CFG_REQ_CMD;
    logic [15:0]        cfg_wdata = 16'd0;

    int                 fail_count;
    int                 pending;
    int                 checked;

    int                 send_idle_pct = 0;
    int                 res_stall_pct = 0;
    bit                 hold_req = 1'b0;
    int                 bytes_sent = 0;
    int                 frames_sent = 0;
    logic [15:0]        cur_cmd;
    logic [7:0]         cur_max;
    logic [7:0]         payload_q[$];
    logic [7:0]         frame_q[$];

    escaped_frame_receiver_unit #(
        .COMMAND_BYTES(CMD_BYTES)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (rx_valid),
        .o_s_axis_tready (rx_ready),
        .i_s_axis_tdata  (rx_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_kind),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    escfr_checker #(
        .COMMAND_BYTES(CMD_BYTES)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (rx_valid),
        .i_s_axis_tready (rx_ready),
        .i_s_axis_tdata  (rx_data),
        .i_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .i_m_axis_tdata  (res_data),
        .i_m_axis_tuser  (res_kind),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                res_ready <= ($urandom_range(99) >= res_stall_pct);
            end
        end
    end

    // End the run when no transaction moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((rx_valid && rx_ready) || (res_valid && res_ready)) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [7:0] other_than(logic [7:0] b);
        return b ^ 8'($urandom_range(1, 255));
    endfunction

    function automatic void fill_payload(int n);
        payload_q.delete();
        repeat (n) payload_q.push_back(($urandom_range(3) == 0) ? ESC_CODE : 8'($urandom));
    endfunction

    // Build the wire bytes of one reply frame; a faulty frame stops at its bad byte
    function automatic void build_frame(t_fault flt);
        logic [15:0] cmd;
        logic [7:0]  len;
        logic [7:0]  sum;
        int          esc_at;
        frame_q.delete();
        cmd = cur_cmd + 16'd1;
        if (flt == FLT_NOISE) begin
            repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
            return;
        end
        if (flt == FLT_START_ESC) begin
            frame_q.push_back(other_than(ESC_CODE));
            return;
        end
        frame_q.push_back(ESC_CODE);
        if (flt == FLT_START) begin
            frame_q.push_back(other_than(START_CODE));
            return;
        end
        frame_q.push_back(START_CODE);
        if (flt == FLT_CMD) cmd = cmd ^ 16'($urandom_range(1, 65535));
        frame_q.push_back(cmd[15:8]);
        frame_q.push_back(cmd[7:0]);
        if (flt == FLT_CMD) return;
        len = (flt == FLT_TOO_LONG) ? 8'($urandom_range(255, cur_max + 1))
                                    : 8'(payload_q.size());
        frame_q.push_back(len);
        if (flt == FLT_TOO_LONG) return;
        sum    = SUM_INIT + cmd[15:8] + cmd[7:0] + len;
        esc_at = (flt == FLT_ESCAPE) ? $urandom_range(payload_q.size() - 1) : -1;
        foreach (payload_q[i]) begin
            if (i == esc_at) begin
                frame_q.push_back(ESC_CODE);
                frame_q.push_back(other_than(ESC_CODE));
                return;
            end
            frame_q.push_back(payload_q[i]);
            if (payload_q[i] == ESC_CODE) frame_q.push_back(ESC_CODE);
            sum = sum + payload_q[i];
        end
        frame_q.push_back((flt == FLT_SUM) ? other_than(sum) : sum);
        if (flt == FLT_SUM) return;
        frame_q.push_back((flt == FLT_END_ESC) ? other_than(ESC_CODE) : ESC_CODE);
        if (flt == FLT_END_ESC) return;
        frame_q.push_back((flt == FLT_END) ? other_than(END_CODE) : END_CODE);
    endfunction

    // Offer one byte after a random gap and hold it until the transaction
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_data  <= b;
        do @(posedge clk); while (!rx_ready);
        bytes_sent++;
    endtask

    task automatic send_frame(t_fault flt);
        build_frame(flt);
        foreach (frame_q[i]) send_byte(frame_q[i]);
        frames_sent++;
    endtask

    task automatic random_frame();
        t_fault flt;
        int     n;
        flt = ($urandom_range(99) < 65) ? FLT_NONE : t_fault'($urandom_range(FLT_NOISE, FLT_END));
        if (flt == FLT_TOO_LONG && cur_max == 8'd255) flt = FLT_NONE;
        if (flt == FLT_ESCAPE && cur_max == 8'd0) flt = FLT_NONE;
        n = $urandom_range(0, (cur_max < 12) ? cur_max : 12);
        if (flt == FLT_ESCAPE && n == 0) n = 1;
        fill_payload(n);
        send_frame(flt);
    endtask

    // Stop offering, wait for every expected result, then cover the pipeline
    task automatic settle();
        rx_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(logic [15:0] cmd, logic [7:0] maxl);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_REQ_CMD;
        cfg_wdata <= cmd;
        @(posedge clk);
        cfg_index <= CFG_MAX_LEN;
        cfg_wdata <= {8'd0, maxl};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  res_stall_pct = 0;  end
            1: begin send_idle_pct = 88; res_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  res_stall_pct = 88; end
            default: begin send_idle_pct = 27; res_stall_pct = 27; end
        endcase
    endtask

    // Stimulus and verdict
    initial begin
        int start_count;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset register values
        cur_cmd = 16'd0;
        cur_max = MAX_LEN_RESET;
        set_idling(0);
        send_byte(8'hFF);
        send_frame(FLT_START);
        fill_payload(0);
        send_frame(FLT_NONE);
        payload_q = '{8'h00, ESC_CODE, 8'hFF};
        send_frame(FLT_NONE);
        send_frame(FLT_TOO_LONG);

        // Random frames per register setting and idling mode
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            case (p)
                0: begin cur_cmd = 16'hFFFF;         cur_max = 8'd0;   end
                1: begin cur_cmd = 16'($urandom);    cur_max = 8'd255; end
                2: begin cur_cmd = 16'h0000;         cur_max = 8'd1;   end
                3: begin cur_cmd = 16'($urandom);    cur_max = 8'($urandom_range(2, 40)); end
                4: begin cur_cmd = 16'h7FFF;         cur_max = 8'd254; end
                5: begin cur_cmd = 16'($urandom);    cur_max = 8'd8;   end
                6: begin cur_cmd = 16'h8000;         cur_max = 8'($urandom); end
                default: begin cur_cmd = 16'h0001;   cur_max = 8'd32;  end
            endcase
            program_regs(cur_cmd, cur_max);
            set_idling(p % 4);
            // let the output back up while the sender keeps offering
            if (p == 4) hold_req = 1'b1;
            if (cur_max == 8'd255) begin
                fill_payload(255);
                send_frame(FLT_NONE);
            end
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_BYTES) random_frame();
        end

        settle();
        $display("Covered %0d bytes in %0d frames over %0d register settings,",
                 bytes_sent, frames_sent, N_PHASES + 1);
        $display("four idling modes and one long output hold-off; %0d results checked.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
